[rtl/sd_host_card_register_model_assert.svh]
// ----------------------------------------------------------------------------
// sd host card register model assertion macros
// concurrent assertion wrappers, empty when synthesis is defined
// ----------------------------------------------------------------------------
`ifndef SD_HOST_CARD_REGISTER_MODEL_ASSERT_SVH
`define SD_HOST_CARD_REGISTER_MODEL_ASSERT_SVH

`ifndef SYNTHESIS

// property checked only outside reset
`define SDHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sdhc assertion failed");

// property checked at every edge, reset included
`define SDHC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sdhc assertion failed");

`else

`define SDHC_ASSERT(lbl, prop)
`define SDHC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[rtl/sdhc_pkg.sv]
// ----------------------------------------------------------------------------
// sdhc_pkg
// shared types and constants of the sd host card register model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdhc_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned ADDR_W      = 41;

  localparam logic OPER_READ  = 1'b0;
  localparam logic OPER_WRITE = 1'b1;

  localparam logic [3:0] REG_PIN     = 4'd0;
  localparam logic [3:0] REG_STATUS  = 4'd1;
  localparam logic [3:0] REG_CONTROL = 4'd2;
  localparam logic [3:0] REG_ARG_LO  = 4'd3;
  localparam logic [3:0] REG_ARG_HI  = 4'd4;
  localparam logic [3:0] REG_FIFO    = 4'd5;
  localparam logic [3:0] REG_DATA    = 4'd6;
  localparam logic [3:0] REG_RESP0   = 4'd7;
  localparam logic [3:0] REG_RESP7   = 4'd14;

  localparam int unsigned EXEC_BIT        = 8;
  localparam int unsigned ST_CMD_DONE_BIT = 11;

  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_ALL_CID     = 6'd2;
  localparam logic [5:0] CMD_REL_ADDR    = 6'd3;
  localparam logic [5:0] CMD_SELECT      = 6'd7;
  localparam logic [5:0] CMD_IF_COND     = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
  localparam logic [5:0] CMD_STOP        = 6'd12;
  localparam logic [5:0] CMD_READ_MULTI  = 6'd18;
  localparam logic [5:0] CMD_WRITE_MULTI = 6'd25;
  localparam logic [5:0] ACMD_OP_COND    = 6'd41;
  localparam logic [5:0] CMD_APP         = 6'd55;

  localparam logic [15:0] CARD_ADDR   = 16'h1234;
  localparam logic [15:0] ST_CMD_DONE = 16'h0800;
  localparam logic [15:0] ST_RSP_DONE = 16'h0200;
  localparam logic [15:0] FIFO_READ   = 16'h0001;
  localparam logic [15:0] FIFO_WRITE  = 16'h2000;
  localparam logic [15:0] PIN_LEVEL   = 16'hBFFF;
  localparam logic [15:0] CSD_WORD    = 16'h4000;

  typedef enum logic [1:0] {
    MODE_NOT_READY   = 2'd0,
    MODE_READY       = 2'd1,
    MODE_BLOCK_READ  = 2'd2,
    MODE_BLOCK_WRITE = 2'd3
  } card_mode_e;

  typedef enum logic [2:0] {
    ROP_NONE,
    ROP_READ,
    ROP_DATA_READ,
    ROP_STATUS_CLR,
    ROP_CTRL_WR,
    ROP_CTRL_EXEC,
    ROP_ARG_LO,
    ROP_ARG_HI
  } reg_op_e;

  typedef struct packed {
    logic    load;
    reg_op_e op;
  } dp_cmd_t;

endpackage

[rtl/sdhc_ctrl.sv]
// ----------------------------------------------------------------------------
// sdhc_ctrl
// handshake state machine and access decoder of the register model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sd_host_card_register_model_assert.svh"

module sdhc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [3:0]         register_index_i,
  input  logic               exec_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sdhc_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   load;

  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_FULL);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (load) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (!load && out_ready_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  // access decode
  always_comb begin
    cmd_o.load = load;
    cmd_o.op   = sdhc_pkg::ROP_NONE;
    if (operation_i == sdhc_pkg::OPER_WRITE) begin
      unique case (register_index_i)
        sdhc_pkg::REG_STATUS:  cmd_o.op = sdhc_pkg::ROP_STATUS_CLR;
        sdhc_pkg::REG_CONTROL: cmd_o.op = exec_i ? sdhc_pkg::ROP_CTRL_EXEC
                                                 : sdhc_pkg::ROP_CTRL_WR;
        sdhc_pkg::REG_ARG_LO:  cmd_o.op = sdhc_pkg::ROP_ARG_LO;
        sdhc_pkg::REG_ARG_HI:  cmd_o.op = sdhc_pkg::ROP_ARG_HI;
        default:               cmd_o.op = sdhc_pkg::ROP_NONE;
      endcase
    end else begin
      unique case (register_index_i)
        sdhc_pkg::REG_DATA: cmd_o.op = sdhc_pkg::ROP_DATA_READ;
        default:            cmd_o.op = sdhc_pkg::ROP_READ;
      endcase
    end
  end

  `SDHC_ASSERT_ALWAYS(a_state_onehot, $onehot(state_q))
  `SDHC_ASSERT(a_load_fills_output, load |=> out_valid_o)

endmodule

[rtl/sdhc_dp.sv]
// ----------------------------------------------------------------------------
// sdhc_dp
// register file, card command execution and stream address datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sd_host_card_register_model_assert.svh"

module sdhc_dp #(
  parameter int unsigned BlockBytes = sdhc_pkg::BLOCK_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sdhc_pkg::dp_cmd_t           cmd_i,
  input  logic [3:0]                  register_index_i,
  input  logic [15:0]                 write_data_i,
  input  logic [7:0]                  image_byte_i,
  output logic [15:0]                 read_data_o,
  output logic [sdhc_pkg::ADDR_W-1:0] next_image_address_o
);

  localparam int unsigned AW = sdhc_pkg::ADDR_W;

  sdhc_pkg::card_mode_e mode_q, mode_d;
  logic                 app_q, app_d;
  logic                 ready_q, ready_d;
  logic [15:0]          status_q, status_d;
  logic [15:0]          control_q, control_d;
  logic [15:0]          arg_lo_q, arg_lo_d;
  logic [15:0]          arg_hi_q, arg_hi_d;
  logic [15:0]          resp_q [8];
  logic [15:0]          resp_d [8];
  logic [AW-1:0]        start_addr_q, start_addr_d;
  logic [31:0]          byte_count_q, byte_count_d;
  logic [15:0]          read_data_q, read_data_d;
  logic [AW-1:0]        addr_q, addr_d;

  logic [AW-1:0]        arg_addr;
  logic [15:0]          r1_hi;
  logic [2:0]           resp_idx;
  logic                 new_sector;

  // block start address from the 32-bit argument
  assign arg_addr = AW'({arg_hi_q, arg_lo_q}) * AW'(BlockBytes);
  assign r1_hi    = {ready_q, 15'h4000};
  assign resp_idx = 3'(register_index_i - sdhc_pkg::REG_RESP0);

  always_comb begin
    mode_d       = mode_q;
    app_d        = app_q;
    ready_d      = ready_q;
    status_d     = status_q;
    control_d    = control_q;
    arg_lo_d     = arg_lo_q;
    arg_hi_d     = arg_hi_q;
    resp_d       = resp_q;
    start_addr_d = start_addr_q;
    byte_count_d = byte_count_q;
    new_sector   = 1'b0;
    read_data_d  = '0;

    if (cmd_i.load) begin
      unique case (cmd_i.op)
        sdhc_pkg::ROP_STATUS_CLR: status_d = status_q & ~write_data_i;
        sdhc_pkg::ROP_CTRL_WR:    control_d = write_data_i;
        sdhc_pkg::ROP_ARG_LO:     arg_lo_d = write_data_i;
        sdhc_pkg::ROP_ARG_HI:     arg_hi_d = write_data_i;
        sdhc_pkg::ROP_DATA_READ: begin
          read_data_d  = {8'h00, image_byte_i};
          byte_count_d = byte_count_q + 32'd1;
        end
        sdhc_pkg::ROP_READ: begin
          case (register_index_i) inside
            sdhc_pkg::REG_PIN:     read_data_d = sdhc_pkg::PIN_LEVEL;
            sdhc_pkg::REG_STATUS:  read_data_d = status_q;
            sdhc_pkg::REG_CONTROL: read_data_d = control_q;
            sdhc_pkg::REG_ARG_LO:  read_data_d = arg_lo_q;
            sdhc_pkg::REG_ARG_HI:  read_data_d = arg_hi_q;
            sdhc_pkg::REG_FIFO: begin
              case (mode_q)
                sdhc_pkg::MODE_BLOCK_READ:  read_data_d = sdhc_pkg::FIFO_READ;
                sdhc_pkg::MODE_BLOCK_WRITE: read_data_d = sdhc_pkg::FIFO_WRITE;
                default:                    read_data_d = '0;
              endcase
            end
            [sdhc_pkg::REG_RESP0:sdhc_pkg::REG_RESP7]: read_data_d = resp_q[resp_idx];
            default: read_data_d = '0;
          endcase
        end
        sdhc_pkg::ROP_CTRL_EXEC: begin
          control_d = write_data_i;
          status_d  = sdhc_pkg::ST_CMD_DONE;
          unique case (write_data_i[5:0])
            sdhc_pkg::CMD_GO_IDLE: begin
              mode_d  = sdhc_pkg::MODE_NOT_READY;
              app_d   = 1'b0;
              ready_d = 1'b0;
            end
            sdhc_pkg::CMD_ALL_CID, sdhc_pkg::CMD_SEND_CSD: begin
              for (int i = 0; i < 8; i++) begin
                resp_d[i] = '0;
              end
              resp_d[1] = (write_data_i[5:0] == sdhc_pkg::CMD_SEND_CSD) ?
                          sdhc_pkg::CSD_WORD : 16'h0000;
              status_d  = sdhc_pkg::ST_CMD_DONE | sdhc_pkg::ST_RSP_DONE;
            end
            sdhc_pkg::CMD_REL_ADDR: begin
              resp_d[0] = '0;
              resp_d[1] = sdhc_pkg::CARD_ADDR;
              status_d  = sdhc_pkg::ST_CMD_DONE | sdhc_pkg::ST_RSP_DONE;
            end
            sdhc_pkg::CMD_SELECT: begin
              resp_d[0] = '0;
              resp_d[1] = r1_hi;
              status_d  = sdhc_pkg::ST_CMD_DONE | sdhc_pkg::ST_RSP_DONE;
            end
            sdhc_pkg::CMD_IF_COND: begin
              resp_d[0] = '0;
              resp_d[1] = r1_hi;
              status_d  = sdhc_pkg::ST_CMD_DONE | sdhc_pkg::ST_RSP_DONE;
              mode_d    = sdhc_pkg::MODE_READY;
              ready_d   = 1'b1;
            end
            sdhc_pkg::CMD_STOP: begin
              mode_d    = sdhc_pkg::MODE_READY;
              resp_d[0] = '0;
              resp_d[1] = r1_hi;
              status_d  = sdhc_pkg::ST_CMD_DONE | sdhc_pkg::ST_RSP_DONE;
            end
            sdhc_pkg::CMD_READ_MULTI, sdhc_pkg::CMD_WRITE_MULTI: begin
              mode_d       = (write_data_i[5:0] == sdhc_pkg::CMD_READ_MULTI) ?
                             sdhc_pkg::MODE_BLOCK_READ : sdhc_pkg::MODE_BLOCK_WRITE;
              start_addr_d = arg_addr;
              byte_count_d = '0;
              new_sector   = 1'b1;
              resp_d[0]    = '0;
              resp_d[1]    = r1_hi;
              status_d     = sdhc_pkg::ST_CMD_DONE | sdhc_pkg::ST_RSP_DONE;
            end
            sdhc_pkg::CMD_APP: begin
              app_d     = 1'b1;
              resp_d[0] = '0;
              resp_d[1] = r1_hi;
              status_d  = sdhc_pkg::ST_CMD_DONE | sdhc_pkg::ST_RSP_DONE;
            end
            sdhc_pkg::ACMD_OP_COND: begin
              if (app_q) begin
                resp_d[0] = '0;
                resp_d[1] = r1_hi;
                status_d  = sdhc_pkg::ST_CMD_DONE | sdhc_pkg::ST_RSP_DONE;
              end
            end
            default: status_d = sdhc_pkg::ST_CMD_DONE;
          endcase
        end
        default: read_data_d = '0;
      endcase
    end

    // stream address after this access
    addr_d = new_sector ? arg_addr : start_addr_q + AW'(byte_count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= sdhc_pkg::MODE_NOT_READY;
      app_q        <= 1'b0;
      ready_q      <= 1'b0;
      status_q     <= '0;
      control_q    <= '0;
      arg_lo_q     <= '0;
      arg_hi_q     <= '0;
      resp_q       <= '{default: '0};
      start_addr_q <= '0;
      byte_count_q <= '0;
    end else begin
      mode_q       <= mode_d;
      app_q        <= app_d;
      ready_q      <= ready_d;
      status_q     <= status_d;
      control_q    <= control_d;
      arg_lo_q     <= arg_lo_d;
      arg_hi_q     <= arg_hi_d;
      resp_q       <= resp_d;
      start_addr_q <= start_addr_d;
      byte_count_q <= byte_count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      read_data_q <= read_data_d;
      addr_q      <= addr_d;
    end
  end

  assign read_data_o          = read_data_q;
  assign next_image_address_o = addr_q;

  `SDHC_ASSERT(a_exec_sets_cmd_done, cmd_i.load && cmd_i.op == sdhc_pkg::ROP_CTRL_EXEC |=> status_q[sdhc_pkg::ST_CMD_DONE_BIT])
  `SDHC_ASSERT(a_data_read_counts, cmd_i.load && cmd_i.op == sdhc_pkg::ROP_DATA_READ |=> byte_count_q == $past(byte_count_q) + 32'd1)
  `SDHC_ASSERT(a_idle_status_stable, !cmd_i.load |=> $stable(status_q))

endmodule

[rtl/sd_host_card_register_model.sv]
// ----------------------------------------------------------------------------
// sd_host_card_register_model
// sd host register block with an attached sdhc card, one bus access per item
// ----------------------------------------------------------------------------
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o  | operation, register_index,
//         |           |                          | write_data, image_byte
// out     | output    | out_valid_o / out_ready_i| read_data, next_image_address
//
// one access per cycle sustained while out_ready_i holds; a result appears the cycle after its transfer
// the output register decouples both sides, a new access enters while the
// previous result is taken in the same cycle
// a stalled output holds off new accesses until it drains
// reset clears all card state and the response halfwords at once
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sd_host_card_register_model #(
  parameter int unsigned BlockBytes = sdhc_pkg::BLOCK_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [3:0]                  register_index_i,
  input  logic [15:0]                 write_data_i,
  input  logic [7:0]                  image_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [15:0]                 read_data_o,
  output logic [sdhc_pkg::ADDR_W-1:0] next_image_address_o
);

  sdhc_pkg::dp_cmd_t cmd;

  sdhc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .register_index_i (register_index_i),
    .exec_i           (write_data_i[sdhc_pkg::EXEC_BIT]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cmd_o            (cmd)
  );

  sdhc_dp #(
    .BlockBytes (BlockBytes)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .register_index_i     (register_index_i),
    .write_data_i         (write_data_i),
    .image_byte_i         (image_byte_i),
    .read_data_o          (read_data_o),
    .next_image_address_o (next_image_address_o)
  );

endmodule
